/* rtl/core/codr_pkg.sv */
// Package for the CMYK ordered-dither rasterizer core.
// Holds the transaction payload types, register index codes and sizing constants.
// No dependencies.
`default_nettype none

package codr_pkg;

  // Sizing of the column counter and the replication count
  localparam int unsigned COL_W      = 12;
  localparam int unsigned MAX_REPEAT = 64;
  localparam int unsigned REP_W      = 7;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ROW0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ROW1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ROW2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ROW3 = 3'd5;

  // Input transaction: one source pixel
  typedef struct packed {
    logic [1:0]       row_phase;
    logic             row_start;
    logic [COL_W-1:0] start_column;
    logic [7:0]       black;
    logic [7:0]       yellow;
    logic [7:0]       magenta;
    logic [7:0]       cyan;
    logic [REP_W-1:0] repeat_req;
    logic             final_pixel;
  } pix_in_t;

  // Output transaction: one printer pixel
  typedef struct packed {
    logic [8:0] byte_index;
    logic [7:0] bit_mask;
    logic       black_dot;
    logic       yellow_dot;
    logic       magenta_dot;
    logic       cyan_dot;
    logic       last_of_pixel;
    logic       row_done;
  } pix_out_t;

endpackage

`default_nettype wire

/* rtl/core/cmyk_ordered_dither_rasterizer_core.sv */
// Top level of the CMYK ordered-dither rasterizer core.
// Depends on codr_pkg for payload types, register codes and sizing constants.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one source pixel
//   per transaction. Output channel (out_valid_o / out_stall_i / out_data_o)
//   carries one printer pixel per transaction: byte index, MSB-first bit mask
//   and the four dot bits. The source pixel is replicated repeat_req times
//   (0 counts as 1, values above 64 saturate to 64).
//   One shared 8-bit magnitude comparator tests the inks in turn under a
//   small sequencer: only black is tested in threshold mode, in greyscale
//   mode and for a black dot in colour mode; otherwise yellow, magenta and
//   cyan are tested as well. The first result of a pixel is registered in the
//   output step, which follows the black step or the cyan step.
//   in_stall_o is high from acceptance until the last result of the pixel is
//   loaded into the output register; the next pixel is then taken even while
//   that result still waits. When out_stall_i holds the output register full,
//   the sequencer waits in its output step and nothing is lost.
//   Reset clears the configuration registers, the column counter and the
//   sequencer; the block is ready as soon as reset is released.
//   Configuration writes are taken at any edge with cfg_we_i high and must
//   only be issued while the block is idle.
`default_nettype none

module cmyk_ordered_dither_rasterizer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [codr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [codr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire codr_pkg::pix_in_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output codr_pkg::pix_out_t                 out_data_o
);
  import codr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BLACK = 6'b000010,
    S_YEL   = 6'b000100,
    S_MAG   = 6'b001000,
    S_CYAN  = 6'b010000,
    S_OUT   = 6'b100000
  } seq_state_e;

  // Configuration registers
  logic [3:0]            thr_q;
  logic                  colour_q;
  logic [CFG_DATA_W-1:0] rows_q [4];

  // Sequencer and pixel context
  seq_state_e       state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [REP_W-1:0] rep_q, rep_d;
  logic [1:0]       phase_q;
  logic [7:0]       black_q, yellow_q, magenta_q, cyan_q;
  logic             fin_q;
  logic             kd_q, yd_q, md_q, cd_q;

  // Output register
  logic     out_valid_q, out_valid_d;
  pix_out_t out_q;

  logic             accept;
  logic             out_load;
  logic             last;
  logic [REP_W-1:0] rep_clamped;
  logic [7:0]       dith;
  logic [7:0]       cmp_a, cmp_b;
  logic             cmp_gt;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign last     = (rep_q == REP_W'(1));

  // Clamp the replication count to 1..MAX_REPEAT
  always_comb begin
    if (in_data_i.repeat_req == '0) begin
      rep_clamped = REP_W'(1);
    end else if (in_data_i.repeat_req > REP_W'(MAX_REPEAT)) begin
      rep_clamped = REP_W'(MAX_REPEAT);
    end else begin
      rep_clamped = in_data_i.repeat_req;
    end
  end

  // Select the dither matrix entry for the current row phase and column
  assign dith = rows_q[phase_q][{col_q[1:0], 3'b000} +: 8];

  // Shared comparator: pick the ink and the reference for this step
  always_comb begin
    case (state_q)
      S_YEL:   cmp_a = yellow_q;
      S_MAG:   cmp_a = magenta_q;
      S_CYAN:  cmp_a = cyan_q;
      default: cmp_a = black_q;
    endcase
    cmp_b  = (thr_q != '0) ? {4'b0000, thr_q ^ 4'hf} : dith;
    cmp_gt = (cmp_a > cmp_b);
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      colour_q  <= 1'b0;
      rows_q[0] <= '0;
      rows_q[1] <= '0;
      rows_q[2] <= '0;
      rows_q[3] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:   thr_q     <= cfg_wdata_i[3:0];
        CFG_COLOUR_MODE: colour_q  <= cfg_wdata_i[0];
        CFG_DITHER_ROW0: rows_q[0] <= cfg_wdata_i;
        CFG_DITHER_ROW1: rows_q[1] <= cfg_wdata_i;
        CFG_DITHER_ROW2: rows_q[2] <= cfg_wdata_i;
        CFG_DITHER_ROW3: rows_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequence the ink tests, column counter and replication count
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    rep_d       = rep_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.row_start) begin
            col_d = in_data_i.start_column;
          end
          rep_d   = rep_clamped;
          state_d = S_BLACK;
        end
      end
      S_BLACK: begin
        if ((thr_q != '0) || cmp_gt || !colour_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_YEL;
        end
      end
      S_YEL:  state_d = S_MAG;
      S_MAG:  state_d = S_CYAN;
      S_CYAN: state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          col_d       = col_q + COL_W'(1);
          rep_d       = rep_q - REP_W'(1);
          state_d     = last ? S_IDLE : S_BLACK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the pixel context on an input transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_q   <= in_data_i.row_phase;
      black_q   <= in_data_i.black;
      yellow_q  <= in_data_i.yellow;
      magenta_q <= in_data_i.magenta;
      cyan_q    <= in_data_i.cyan;
      fin_q     <= in_data_i.final_pixel;
    end
  end

  // Record the comparator result of each ink step
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_BLACK: begin
        kd_q <= cmp_gt;
        yd_q <= 1'b0;
        md_q <= 1'b0;
        cd_q <= 1'b0;
      end
      S_YEL:   yd_q <= cmp_gt;
      S_MAG:   md_q <= cmp_gt;
      S_CYAN:  cd_q <= cmp_gt;
      default: ;
    endcase
  end

  // Load the output register with one printer pixel
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.byte_index    <= col_q[COL_W-1:3];
      out_q.bit_mask      <= 8'h80 >> col_q[2:0];
      out_q.black_dot     <= kd_q;
      out_q.yellow_dot    <= yd_q;
      out_q.magenta_dot   <= md_q;
      out_q.cyan_dot      <= cd_q;
      out_q.last_of_pixel <= last;
      out_q.row_done      <= last && fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Idle exactly when no replicas are pending
  a_idle_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) == (rep_q == '0))
    else $error("replication count out of step with sequencer");

  // Never show a colour dot together with a black dot
  a_dot_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.black_dot &&
      (out_data_o.yellow_dot || out_data_o.magenta_dot || out_data_o.cyan_dot)))
    else $error("colour dot set under a black dot");

  // Row end only on the last replica
  a_row_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.row_done |-> out_data_o.last_of_pixel)
    else $error("row_done without last_of_pixel");

  // Advance the column by one on each result load
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (col_q == $past(col_q) + COL_W'(1)))
    else $error("column counter did not advance");

endmodule

`default_nettype wire
